@@ rtl/core/y86_execute_stage_core_assert.svh @@
// Assertion macros for the execute stage core.
`ifndef Y86_EXECUTE_STAGE_CORE_ASSERT_SVH
`define Y86_EXECUTE_STAGE_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define Y86EX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define Y86EX_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/y86ex_pkg.sv @@
package y86ex_pkg;

	localparam int unsigned WORD_W = 64;

	localparam logic [3:0] IC_NOP    = 4'd1;
	localparam logic [3:0] IC_RRMOVQ = 4'd2;
	localparam logic [3:0] IC_IRMOVQ = 4'd3;
	localparam logic [3:0] IC_RMMOVQ = 4'd4;
	localparam logic [3:0] IC_MRMOVQ = 4'd5;
	localparam logic [3:0] IC_OPQ    = 4'd6;
	localparam logic [3:0] IC_JXX    = 4'd7;
	localparam logic [3:0] IC_CALL   = 4'd8;
	localparam logic [3:0] IC_RET    = 4'd9;
	localparam logic [3:0] IC_PUSHQ  = 4'd10;
	localparam logic [3:0] IC_POPQ   = 4'd11;

	localparam logic [3:0] ALU_ADD = 4'd0;
	localparam logic [3:0] ALU_SUB = 4'd1;
	localparam logic [3:0] ALU_AND = 4'd2;
	localparam logic [3:0] ALU_XOR = 4'd3;

	localparam logic [3:0] COND_ALWAYS = 4'd0;
	localparam logic [3:0] COND_LE     = 4'd1;
	localparam logic [3:0] COND_L      = 4'd2;
	localparam logic [3:0] COND_E      = 4'd3;
	localparam logic [3:0] COND_NE     = 4'd4;
	localparam logic [3:0] COND_GE     = 4'd5;
	localparam logic [3:0] COND_G      = 4'd6;

	localparam logic [3:0] REG_NONE = 4'd15;
	localparam logic [1:0] STAT_OK  = 2'd0;

	localparam logic [WORD_W-1:0] STACK_DOWN = 64'hFFFF_FFFF_FFFF_FFF8;
	localparam logic [WORD_W-1:0] STACK_UP   = 64'd8;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic zero;
		logic sign;
		logic overflow;
	} flags_t;

endpackage

@@ rtl/core/y86_execute_stage_core.sv @@
// Y86-64 execute stage. Instructions arrive on the inst channel and leave as
// memory-stage register contents on the res channel. Sustained rate is one
// instruction per clock while res is not stalled. An inst transfer loads the
// input register, and the result register then loads from it and drives res.
// The rate is set by the condition-code loop: the flags written by an OPq
// at its transfer into the result register are read by the very next
// instruction's jXX/cmovXX condition in the following cycle. Operand
// selection, the single 64-bit adder/logic unit and the condition evaluation
// sit between the two registers. When m_stat or w_stat is nonzero the
// instruction is replaced by a nop bubble and the flags are held. Flags reset
// to zero=1, sign=0, overflow=0.
`include "y86_execute_stage_core_assert.svh"

module y86_execute_stage_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  inst_valid,
	output logic                  inst_stall,
	input  logic [3:0]            icode,
	input  logic [3:0]            ifun,
	input  y86ex_pkg::word_t      val_a,
	input  y86ex_pkg::word_t      val_b,
	input  y86ex_pkg::word_t      val_c,
	input  logic [3:0]            dst_e,
	input  logic [3:0]            dst_m,
	input  logic [1:0]            stat,
	input  logic [1:0]            m_stat,
	input  logic [1:0]            w_stat,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [1:0]            out_stat,
	output logic [3:0]            out_icode,
	output logic                  cond_flag,
	output y86ex_pkg::word_t      val_e,
	output y86ex_pkg::word_t      pass_val_a,
	output logic [3:0]            out_dst_e,
	output logic [3:0]            out_dst_m,
	output logic                  bubbled
);
	import y86ex_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [3:0] icode_s1, ifun_s1, dst_e_s1, dst_m_s1;
	logic [1:0] stat_s1, m_stat_s1, w_stat_s1;
	word_t      val_a_s1, val_b_s1, val_c_s1;

	// Result register.
	logic       valid_s2;
	logic [1:0] stat_s2;
	logic [3:0] icode_s2, dst_e_s2, dst_m_s2;
	logic       cnd_s2, bubble_s2;
	word_t      val_e_s2, val_a_s2;

	flags_t flags_q;

	logic  s2_free, adv_s1, take_in;
	logic  bubble, known, is_sub, cnd, lt, update_flags;
	logic [3:0] alu_fn, dst_e_eff;
	word_t alu_a, alu_b, opnd, sum, alu_r;
	logic  ovf;

	// Result register empties when the downstream side takes it.
	assign s2_free    = !valid_s2 || !res_stall;
	assign adv_s1     = valid_s1 && s2_free;
	assign inst_stall = valid_s1 && !s2_free;
	assign take_in    = inst_valid && !inst_stall;

	// Operand selection by instruction code.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (icode_s1)
			IC_RRMOVQ, IC_OPQ:             alu_a = val_a_s1;
			IC_IRMOVQ, IC_RMMOVQ, IC_MRMOVQ: alu_a = val_c_s1;
			IC_CALL, IC_PUSHQ:             alu_a = STACK_DOWN;
			IC_RET, IC_POPQ:               alu_a = STACK_UP;
			default:                       alu_a = '0;
		endcase
		case (icode_s1)
			IC_RMMOVQ, IC_MRMOVQ, IC_OPQ, IC_CALL, IC_PUSHQ, IC_RET, IC_POPQ:
				alu_b = val_b_s1;
			default:
				alu_b = '0;
		endcase
	end

	// One adder serves add and subtract (b - a = b + ~a + 1).
	assign alu_fn = (icode_s1 == IC_OPQ) ? ifun_s1 : ALU_ADD;
	assign is_sub = (alu_fn == ALU_SUB);
	assign opnd   = is_sub ? ~alu_a : alu_a;
	assign sum    = alu_b + opnd + {{(WORD_W-1){1'b0}}, is_sub};

	always_comb begin
		known = 1'b1;
		ovf   = 1'b0;
		case (alu_fn)
			ALU_ADD, ALU_SUB: begin
				alu_r = sum;
				ovf   = (opnd[WORD_W-1] == alu_b[WORD_W-1]) &&
				        (sum[WORD_W-1] != alu_b[WORD_W-1]);
			end
			ALU_AND: alu_r = alu_a & alu_b;
			ALU_XOR: alu_r = alu_a ^ alu_b;
			default: begin
				alu_r = '0;
				known = 1'b0;
			end
		endcase
	end

	// Condition from the flags as they stand before this instruction.
	assign lt = flags_q.sign != flags_q.overflow;
	always_comb begin
		cnd = 1'b0;
		if (icode_s1 == IC_JXX || icode_s1 == IC_RRMOVQ) begin
			case (ifun_s1)
				COND_ALWAYS: cnd = 1'b1;
				COND_LE:     cnd = lt || flags_q.zero;
				COND_L:      cnd = lt;
				COND_E:      cnd = flags_q.zero;
				COND_NE:     cnd = !flags_q.zero;
				COND_GE:     cnd = !lt;
				COND_G:      cnd = !lt && !flags_q.zero;
				default:     cnd = 1'b0;
			endcase
		end
	end

	assign bubble       = (m_stat_s1 != STAT_OK) || (w_stat_s1 != STAT_OK);
	assign update_flags = adv_s1 && (icode_s1 == IC_OPQ) && !bubble && known;
	// Drop the destination of a failed cmov.
	assign dst_e_eff    = (icode_s1 == IC_RRMOVQ && !cnd) ? REG_NONE : dst_e_s1;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '{zero: 1'b1, sign: 1'b0, overflow: 1'b0};
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (update_flags) begin
				flags_q <= '{zero: (alu_r == '0), sign: alu_r[WORD_W-1], overflow: ovf};
			end
		end
	end

	// Payload: both registers load on their transfers, hold otherwise.
	always_ff @(posedge clk) begin
		if (take_in) begin
			icode_s1  <= icode;
			ifun_s1   <= ifun;
			val_a_s1  <= val_a;
			val_b_s1  <= val_b;
			val_c_s1  <= val_c;
			dst_e_s1  <= dst_e;
			dst_m_s1  <= dst_m;
			stat_s1   <= stat;
			m_stat_s1 <= m_stat;
			w_stat_s1 <= w_stat;
		end
		if (adv_s1) begin
			if (bubble) begin
				stat_s2   <= STAT_OK;
				icode_s2  <= IC_NOP;
				cnd_s2    <= 1'b0;
				val_e_s2  <= '0;
				val_a_s2  <= '0;
				dst_e_s2  <= REG_NONE;
				dst_m_s2  <= REG_NONE;
				bubble_s2 <= 1'b1;
			end else begin
				stat_s2   <= stat_s1;
				icode_s2  <= icode_s1;
				cnd_s2    <= cnd;
				val_e_s2  <= alu_r;
				val_a_s2  <= val_a_s1;
				dst_e_s2  <= dst_e_eff;
				dst_m_s2  <= dst_m_s1;
				bubble_s2 <= 1'b0;
			end
		end
	end

	assign res_valid  = valid_s2;
	assign out_stat   = stat_s2;
	assign out_icode  = icode_s2;
	assign cond_flag  = cnd_s2;
	assign val_e      = val_e_s2;
	assign pass_val_a = val_a_s2;
	assign out_dst_e  = dst_e_s2;
	assign out_dst_m  = dst_m_s2;
	assign bubbled    = bubble_s2;

	`Y86EX_ASSERT(a_flags_hold, !update_flags |=> $stable(flags_q), "flags changed without an OPq transfer")
	`Y86EX_ASSERT(a_bubble_nop, (valid_s2 && bubble_s2) |-> (icode_s2 == IC_NOP && dst_e_s2 == REG_NONE && dst_m_s2 == REG_NONE && !cnd_s2), "bubble is not a clean nop")
	`Y86EX_ASSERT(a_cmov_cancel, (valid_s2 && !bubble_s2 && icode_s2 == IC_RRMOVQ && !cnd_s2) |-> (dst_e_s2 == REG_NONE), "failed cmov kept its destination")
	`Y86EX_ASSERT(a_stall_keeps, inst_stall |=> valid_s1, "stalled input register lost its item")
	`Y86EX_ASSERT_ALWAYS(a_stall_valid, inst_stall |-> valid_s1, "stall raised with an empty input register")

endmodule
